/* src/lpc_bus_target_cycle_engine_unit_macros.svh */
// Assertion macros used by the checker file of the LPC target cycle engine.
// Depends on nothing; include by bare file name.
`ifndef LPC_BUS_TARGET_CYCLE_ENGINE_UNIT_MACROS_SVH
`define LPC_BUS_TARGET_CYCLE_ENGINE_UNIT_MACROS_SVH

// Checked at every rising clock edge while reset is low.
`define LBT_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LBT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/lbt_pkg.sv */
// Package for the LPC target cycle engine: payload structs, phase enum and bus codes.
// Depends on nothing.
`default_nettype none

package lbt_pkg;

   typedef struct packed {
      logic [3:0] lad_in;
      logic [7:0] backend_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  lad_out;
      logic        lad_drive;
      logic        lframe_hold_low;
      logic        request_valid;
      logic [1:0]  request_kind;
      logic [31:0] request_address;
      logic [7:0]  request_write_data;
      logic        cycle_end;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_START = 4'd0,
      PH_TYPE  = 4'd1,
      PH_ADDR  = 4'd2,
      PH_WDATA = 4'd3,
      PH_TAR1  = 4'd4,
      PH_TAR2  = 4'd5,
      PH_SYNC5 = 4'd6,
      PH_SYNC0 = 4'd7,
      PH_RDATA = 4'd8,
      PH_TEND1 = 4'd9,
      PH_TEND2 = 4'd10
   } phase_type;

   // Bit positions inside the 2-bit cycle kind.
   localparam int unsigned KIND_WRITE_BIT = 0;
   localparam int unsigned KIND_MEM_BIT   = 1;

   localparam logic [3:0] LAD_START      = 4'h0;
   localparam logic [3:0] LAD_SYNC_READY = 4'h5;
   localparam logic [3:0] LAD_SYNC_DONE  = 4'h0;
   localparam logic [3:0] LAD_TURN       = 4'hF;
   localparam int unsigned TYPE_INVALID_BIT = 3;

   localparam logic [3:0] NIBBLES_IO   = 4'd4;
   localparam logic [3:0] NIBBLES_MEM  = 4'd8;
   localparam logic [3:0] NIBBLES_DATA = 4'd2;
   localparam logic [3:0] NIBBLES_LAST = 4'd1;
   localparam logic [3:0] NIBBLES_NONE = 4'd0;

   // Register index is taken from byte address bit 2.
   localparam logic CSR_ENABLED_KINDS = 1'b0;

endpackage

`default_nettype wire

/* src/lpc_bus_target_cycle_engine_unit.sv */
// LPC bus target cycle engine: decodes IO and memory cycles from LAD nibbles.
// Depends on lbt_pkg.
//
// Usage: each transfer on the req_ channel is one LPC clock: the LAD nibble the
// host drove plus the backend read byte. Each such transfer produces exactly one
// transfer on the rsp_ channel with what the target drives on LAD that clock,
// the LFRAME hold, the backend request strobe with kind, address and write byte,
// and the end-of-cycle flag.
// The result of a transfer is registered: it is valid right after the edge that
// accepts it. Throughput is one transfer per cycle while the receiver takes each
// result; the phase register and the result register are the only stages, and
// the next phase depends only on the engine state and the nibble just taken.
// A new transfer is accepted whenever the result register is empty or its
// content is taken in the same cycle, so a stalled receiver stalls the input
// after one result.
// The enabled_kinds register sits at byte address 0 of the csr_ port; a kind
// whose bit is clear runs the bus handshake without a backend request.
// Synchronous reset returns to waiting for a start nibble, clears
// enabled_kinds and empties the result register.
`default_nettype none

module lpc_bus_target_cycle_engine_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lbt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lbt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   lbt_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  nibbles_ff, nibbles_in;
   logic        lframe_ff, lframe_in;
   logic [3:0]  enabled_ff;
   logic        rsp_valid_ff;
   lbt_pkg::rsp_type rsp_data_ff, result;
   logic        accept;
   logic        kind_enabled;
   logic [3:0]  nibbles_dec;

   // Configuration port.
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == lbt_pkg::CSR_ENABLED_KINDS) begin
         csr_prdata = {28'd0, enabled_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 4'd0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == lbt_pkg::CSR_ENABLED_KINDS)) begin
         enabled_ff <= csr_pwdata[3:0];
      end
   end

   assign accept       = req_valid && req_ready;
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign kind_enabled = enabled_ff[kind_ff];
   assign nibbles_dec  = nibbles_ff - 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      nibbles_in = nibbles_ff;
      lframe_in  = lframe_ff;
      result     = '0;
      unique case (phase_ff)
         lbt_pkg::PH_TYPE: begin
            if (req_data.lad_in[lbt_pkg::TYPE_INVALID_BIT]) begin
               phase_in = lbt_pkg::PH_START;
            end else begin
               kind_in = req_data.lad_in[2:1];
               addr_in = 32'd0;
               data_in = 8'd0;
               if (kind_in[lbt_pkg::KIND_MEM_BIT]) begin
                  nibbles_in = lbt_pkg::NIBBLES_MEM;
                  lframe_in  = 1'b1;
               end else begin
                  nibbles_in = lbt_pkg::NIBBLES_IO;
               end
               phase_in = lbt_pkg::PH_ADDR;
            end
         end
         lbt_pkg::PH_ADDR: begin
            addr_in    = {addr_ff[27:0], req_data.lad_in};
            nibbles_in = nibbles_dec;
            if (nibbles_dec == lbt_pkg::NIBBLES_NONE) begin
               if (kind_ff[lbt_pkg::KIND_WRITE_BIT]) begin
                  nibbles_in = lbt_pkg::NIBBLES_DATA;
                  phase_in   = lbt_pkg::PH_WDATA;
               end else begin
                  phase_in = lbt_pkg::PH_TAR1;
               end
            end
         end
         lbt_pkg::PH_WDATA: begin
            // Write data arrives low nibble first.
            if (nibbles_ff == lbt_pkg::NIBBLES_DATA) begin
               data_in = {4'd0, req_data.lad_in};
            end else begin
               data_in = {req_data.lad_in, data_ff[3:0]};
            end
            nibbles_in = nibbles_dec;
            if (nibbles_dec == lbt_pkg::NIBBLES_NONE) begin
               phase_in = lbt_pkg::PH_TAR1;
            end
         end
         lbt_pkg::PH_TAR1: begin
            phase_in = lbt_pkg::PH_TAR2;
         end
         lbt_pkg::PH_TAR2: begin
            result.lad_drive = 1'b1;
            result.lad_out   = lbt_pkg::LAD_TURN;
            phase_in         = lbt_pkg::PH_SYNC5;
         end
         lbt_pkg::PH_SYNC5: begin
            result.lad_drive = 1'b1;
            result.lad_out   = lbt_pkg::LAD_SYNC_READY;
            if (kind_enabled) begin
               result.request_valid   = 1'b1;
               result.request_kind    = kind_ff;
               result.request_address = addr_ff;
               if (kind_ff[lbt_pkg::KIND_WRITE_BIT]) begin
                  result.request_write_data = data_ff;
               end
            end
            phase_in = lbt_pkg::PH_SYNC0;
         end
         lbt_pkg::PH_SYNC0: begin
            result.lad_drive = 1'b1;
            result.lad_out   = lbt_pkg::LAD_SYNC_DONE;
            if (kind_ff[lbt_pkg::KIND_WRITE_BIT]) begin
               phase_in = lbt_pkg::PH_TEND1;
            end else begin
               data_in    = kind_enabled ? req_data.backend_byte : 8'd0;
               nibbles_in = lbt_pkg::NIBBLES_DATA;
               phase_in   = lbt_pkg::PH_RDATA;
            end
         end
         lbt_pkg::PH_RDATA: begin
            result.lad_drive = 1'b1;
            if (nibbles_ff == lbt_pkg::NIBBLES_DATA) begin
               result.lad_out = data_ff[3:0];
               nibbles_in     = lbt_pkg::NIBBLES_LAST;
            end else begin
               result.lad_out = data_ff[7:4];
               nibbles_in     = lbt_pkg::NIBBLES_NONE;
               phase_in       = lbt_pkg::PH_TEND1;
            end
         end
         lbt_pkg::PH_TEND1: begin
            result.lad_drive = 1'b1;
            result.lad_out   = lbt_pkg::LAD_TURN;
            phase_in         = lbt_pkg::PH_TEND2;
         end
         lbt_pkg::PH_TEND2: begin
            lframe_in        = 1'b0;
            result.cycle_end = 1'b1;
            phase_in         = lbt_pkg::PH_START;
         end
         default: begin
            // Waiting for start; unused phase codes land here as well.
            phase_in = (req_data.lad_in == lbt_pkg::LAD_START) ?
                       lbt_pkg::PH_TYPE : lbt_pkg::PH_START;
         end
      endcase
      result.lframe_hold_low = lframe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lbt_pkg::PH_START;
         kind_ff    <= 2'd0;
         addr_ff    <= 32'd0;
         data_ff    <= 8'd0;
         nibbles_ff <= 4'd0;
         lframe_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         nibbles_ff <= nibbles_in;
         lframe_ff  <= lframe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* src/lbt_checker.sv */
// Port-level checker for the LPC target cycle engine, bound to its top level.
// Depends on lbt_pkg and lpc_bus_target_cycle_engine_unit_macros.svh.
`default_nettype none

`include "lpc_bus_target_cycle_engine_unit_macros.svh"

module lbt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire lbt_pkg::rsp_type rsp_data
);

   // A stalled result transfer keeps its content.
   `LBT_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // The input is never stalled while the result register can take a new item.
   `LBT_ASSERT_RUN(a_ready_free, clock, reset, !rsp_valid || rsp_ready |-> req_ready, "input stalled with room in the result register")

   // Nothing is driven on LAD unless the drive enable is set.
   `LBT_ASSERT_RUN(a_lad_quiet, clock, reset, rsp_valid && !rsp_data.lad_drive |-> rsp_data.lad_out == 4'd0, "LAD nibble set without drive")

   // Request fields stay zero without a request strobe.
   `LBT_ASSERT_RUN(a_req_quiet, clock, reset, rsp_valid && !rsp_data.request_valid |-> rsp_data.request_kind == 2'd0 && rsp_data.request_address == 32'd0 && rsp_data.request_write_data == 8'd0, "request fields set without strobe")

   // Reset leaves no result pending.
   `LBT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind lpc_bus_target_cycle_engine_unit lbt_checker u_lbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/sv/tb_lpc_bus_target_cycle_engine_unit.sv */
// Self-checking testbench for the LPC target cycle engine: a queue-fed driver, a monitor
// and a clock-by-clock predictor of the LAD and backend outputs under random stalls.
// Depends on lbt_pkg and lpc_bus_target_cycle_engine_unit.
`timescale 1ns / 1ps

module tb_lpc_bus_target_cycle_engine_unit;

   localparam logic [2:0] CSR_ADDR_ENABLED_KINDS = 3'd0;
   localparam logic [2:0] CSR_ADDR_BEYOND        = 3'd4;
   localparam logic [1:0] KIND_MEM_WRITE         = 2'd3;
   localparam int unsigned MAX_REPORTS           = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lbt_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lbt_pkg::rsp_type rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lbt_pkg::req_type bus_clocks[$];
   lbt_pkg::rsp_type expected_rsp[$];
   lbt_pkg::rsp_type oldest_rsp;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned failures = 0;

   // Predictor copy of the engine state.
   lbt_pkg::phase_type lpc_phase = lbt_pkg::PH_START;
   logic [1:0]  lpc_kind = '0;
   logic [31:0] lpc_address = '0;
   logic [7:0]  lpc_data = '0;
   logic [3:0]  lpc_left = '0;
   logic        lpc_frame_held = 1'b0;
   logic [3:0]  enabled_kinds_model = '0;

   lpc_bus_target_cycle_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the engine by one LPC clock and returns what it drives on that clock.
   function automatic lbt_pkg::rsp_type predict_bus_clock(lbt_pkg::req_type item);
      lbt_pkg::rsp_type r;
      logic [3:0] lad;
      r = '0;
      lad = item.lad_in;
      case (lpc_phase)
         lbt_pkg::PH_TYPE: begin
            if (lad[lbt_pkg::TYPE_INVALID_BIT]) begin
               lpc_phase = lbt_pkg::PH_START;
            end else begin
               lpc_kind = lad[2:1];
               lpc_address = '0;
               lpc_data = '0;
               if (lpc_kind[lbt_pkg::KIND_MEM_BIT]) begin
                  lpc_left = lbt_pkg::NIBBLES_MEM;
                  lpc_frame_held = 1'b1;
               end else begin
                  lpc_left = lbt_pkg::NIBBLES_IO;
               end
               lpc_phase = lbt_pkg::PH_ADDR;
            end
         end
         lbt_pkg::PH_ADDR: begin
            lpc_address = {lpc_address[27:0], lad};
            lpc_left = lpc_left - 4'd1;
            if (lpc_left == lbt_pkg::NIBBLES_NONE) begin
               if (lpc_kind[lbt_pkg::KIND_WRITE_BIT]) begin
                  lpc_left = lbt_pkg::NIBBLES_DATA;
                  lpc_phase = lbt_pkg::PH_WDATA;
               end else begin
                  lpc_phase = lbt_pkg::PH_TAR1;
               end
            end
         end
         lbt_pkg::PH_WDATA: begin
            if (lpc_left == lbt_pkg::NIBBLES_DATA) lpc_data = {4'h0, lad};
            else lpc_data = {lad, lpc_data[3:0]};
            lpc_left = lpc_left - 4'd1;
            if (lpc_left == lbt_pkg::NIBBLES_NONE) lpc_phase = lbt_pkg::PH_TAR1;
         end
         lbt_pkg::PH_TAR1: lpc_phase = lbt_pkg::PH_TAR2;
         lbt_pkg::PH_TAR2: begin
            r.lad_drive = 1'b1;
            r.lad_out = lbt_pkg::LAD_TURN;
            lpc_phase = lbt_pkg::PH_SYNC5;
         end
         lbt_pkg::PH_SYNC5: begin
            r.lad_drive = 1'b1;
            r.lad_out = lbt_pkg::LAD_SYNC_READY;
            if (enabled_kinds_model[lpc_kind]) begin
               r.request_valid = 1'b1;
               r.request_kind = lpc_kind;
               r.request_address = lpc_address;
               if (lpc_kind[lbt_pkg::KIND_WRITE_BIT]) r.request_write_data = lpc_data;
            end
            lpc_phase = lbt_pkg::PH_SYNC0;
         end
         lbt_pkg::PH_SYNC0: begin
            r.lad_drive = 1'b1;
            r.lad_out = lbt_pkg::LAD_SYNC_DONE;
            if (lpc_kind[lbt_pkg::KIND_WRITE_BIT]) begin
               lpc_phase = lbt_pkg::PH_TEND1;
            end else begin
               // A disabled kind ignores the backend and returns a zero byte.
               lpc_data = enabled_kinds_model[lpc_kind] ? item.backend_byte : 8'h00;
               lpc_left = lbt_pkg::NIBBLES_DATA;
               lpc_phase = lbt_pkg::PH_RDATA;
            end
         end
         lbt_pkg::PH_RDATA: begin
            r.lad_drive = 1'b1;
            if (lpc_left == lbt_pkg::NIBBLES_DATA) begin
               r.lad_out = lpc_data[3:0];
               lpc_left = lbt_pkg::NIBBLES_LAST;
            end else begin
               r.lad_out = lpc_data[7:4];
               lpc_left = lbt_pkg::NIBBLES_NONE;
               lpc_phase = lbt_pkg::PH_TEND1;
            end
         end
         lbt_pkg::PH_TEND1: begin
            r.lad_drive = 1'b1;
            r.lad_out = lbt_pkg::LAD_TURN;
            lpc_phase = lbt_pkg::PH_TEND2;
         end
         lbt_pkg::PH_TEND2: begin
            lpc_frame_held = 1'b0;
            r.cycle_end = 1'b1;
            lpc_phase = lbt_pkg::PH_START;
         end
         default: lpc_phase = (lad == lbt_pkg::LAD_START) ? lbt_pkg::PH_TYPE
                                                          : lbt_pkg::PH_START;
      endcase
      r.lframe_hold_low = lpc_frame_held;
      return r;
   endfunction

   function automatic void push_bus_clock(logic [3:0] lad, logic [7:0] rd);
      lbt_pkg::req_type item;
      item.lad_in = lad;
      item.backend_byte = rd;
      bus_clocks.push_back(item);
   endfunction

   function automatic logic [3:0] any_nibble();
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Queues one complete host cycle of the given kind; returns the number of items queued.
   function automatic int unsigned queue_lpc_cycle(logic [1:0] kind);
      int unsigned addr_nibbles;
      int unsigned tail;
      int unsigned style;
      int unsigned n;
      logic [3:0]  nib;
      addr_nibbles = kind[lbt_pkg::KIND_MEM_BIT] ? 8 : 4;
      style = $urandom_range(0, 9);
      n = 0;
      push_bus_clock(lbt_pkg::LAD_START, any_byte());
      push_bus_clock({1'b0, kind, 1'($urandom_range(0, 1))}, any_byte());
      n = 2;
      for (int unsigned i = 0; i < addr_nibbles; i++) begin
         nib = (style == 0) ? 4'h0 : (style == 1) ? 4'hF : any_nibble();
         push_bus_clock(nib, any_byte());
         n++;
      end
      if (kind[lbt_pkg::KIND_WRITE_BIT]) begin
         push_bus_clock(any_nibble(), any_byte());
         push_bus_clock(any_nibble(), any_byte());
         n += 2;
      end
      // Turnaround, sync, read data and closing turnaround clocks; LAD content is don't-care.
      tail = kind[lbt_pkg::KIND_WRITE_BIT] ? 6 : 8;
      for (int unsigned i = 0; i < tail; i++) begin
         push_bus_clock(any_nibble(), any_byte());
         n++;
      end
      return n;
   endfunction

   // Mostly well-formed cycles, some aborted by an unknown type nibble, some idle noise.
   function automatic void queue_random_traffic(int unsigned count);
      int unsigned queued;
      int unsigned pick;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            queued += queue_lpc_cycle(2'($urandom_range(0, 3)));
         end else if (pick < 92) begin
            push_bus_clock(lbt_pkg::LAD_START, any_byte());
            push_bus_clock({1'b1, 3'($urandom_range(0, 7))}, any_byte());
            queued += 2;
         end else begin
            push_bus_clock(any_nibble(), any_byte());
            queued++;
         end
      end
   endfunction

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == CSR_ADDR_ENABLED_KINDS) enabled_kinds_model = value[3:0];
      @(negedge clock);
   endtask

   // Holds off new stimulus until every expected transfer has come back.
   task automatic wait_drained();
      while (bus_clocks.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic report_failure(input string what, input lbt_pkg::rsp_type want,
                                 input lbt_pkg::rsp_type got);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
         $display("  expected lad=%h drv=%b frame=%b req=%b kind=%0d addr=%h wd=%h end=%b",
                  want.lad_out, want.lad_drive, want.lframe_hold_low, want.request_valid,
                  want.request_kind, want.request_address, want.request_write_data,
                  want.cycle_end);
         $display("  actual   lad=%h drv=%b frame=%b req=%b kind=%0d addr=%h wd=%h end=%b",
                  got.lad_out, got.lad_drive, got.lframe_hold_low, got.request_valid,
                  got.request_kind, got.request_address, got.request_write_data,
                  got.cycle_end);
      end
   endtask

   // Driver: presents queued bus items and predicts each one as its transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsp.push_back(predict_bus_clock(req_data));
         if (!req_valid || req_ready) begin
            if (bus_clocks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= bus_clocks.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_failure("result transfer with nothing expected", '0, rsp_data);
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               if (rsp_data.lad_out !== oldest_rsp.lad_out
                   || rsp_data.lad_drive !== oldest_rsp.lad_drive
                   || rsp_data.lframe_hold_low !== oldest_rsp.lframe_hold_low
                   || rsp_data.request_valid !== oldest_rsp.request_valid
                   || rsp_data.request_kind !== oldest_rsp.request_kind
                   || rsp_data.request_address !== oldest_rsp.request_address
                   || rsp_data.request_write_data !== oldest_rsp.request_write_data
                   || rsp_data.cycle_end !== oldest_rsp.cycle_end)
                  report_failure("result mismatch", oldest_rsp, rsp_data);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 58;
      write_csr(CSR_ADDR_ENABLED_KINDS, 32'h0000_000F);

      // Unknown type, an idle nibble, then a memory write at the top address with data 0xFF.
      push_bus_clock(lbt_pkg::LAD_START, 8'h00);
      push_bus_clock(4'hF, 8'hFF);
      push_bus_clock(lbt_pkg::LAD_TURN, 8'h00);
      push_bus_clock(lbt_pkg::LAD_START, 8'hFF);
      push_bus_clock({1'b0, KIND_MEM_WRITE, 1'b1}, 8'h00);
      for (int i = 0; i < 10; i++) push_bus_clock(4'hF, 8'hFF);
      for (int i = 0; i < 6; i++) push_bus_clock(4'h0, 8'hFF);
      wait_drained();

      queue_random_traffic(150);
      wait_drained();

      // Every kind disabled: the bus handshake runs without backend requests.
      write_csr(CSR_ADDR_BEYOND, $urandom());
      write_csr(CSR_ADDR_ENABLED_KINDS, 32'h0000_0000);
      queue_random_traffic(150);
      wait_drained();

      send_idle_pct = 58;
      recv_idle_pct = 15;
      write_csr(CSR_ADDR_ENABLED_KINDS, $urandom());
      queue_random_traffic(150);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_ADDR_ENABLED_KINDS, $urandom());
      queue_random_traffic(150);
      wait_drained();

      repeat (10) @(negedge clock);
      if (failures == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/lbt_pkg.sv
src/lpc_bus_target_cycle_engine_unit.sv
src/lbt_checker.sv
tb/sv/tb_lpc_bus_target_cycle_engine_unit.sv
